// ===== src/sh24_pkg.sv =====
package sh24_pkg;

   // Field widths
   localparam int NonceWidth = 32;
   localparam int HashWidth  = 32;
   localparam int WordWidth  = 64;

   // Configuration register map
   localparam int CsrIndexWidth = 2;
   localparam logic [CsrIndexWidth-1:0] CSR_INIT_WORD0 = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_INIT_WORD1 = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_INIT_WORD2 = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_INIT_WORD3 = 2'd3;

   // Schedule: two rounds, nonce and 0xff injection, four more rounds
   localparam int NumRounds    = 6;
   localparam int InjectRound  = 2;
   localparam int PipeDepth    = 2 * NumRounds + 1;
   localparam int CountWidth   = $clog2(PipeDepth + 1);
   localparam logic [WordWidth-1:0] FinalXorV2 = 64'hff;

   // Rotation amounts
   localparam int RotB1 = 13;
   localparam int RotD1 = 16;
   localparam int RotA  = 32;
   localparam int RotD2 = 21;
   localparam int RotB2 = 17;

   typedef struct packed {
      logic [WordWidth-1:0] v0;
      logic [WordWidth-1:0] v1;
      logic [WordWidth-1:0] v2;
      logic [WordWidth-1:0] v3;
   } state_type;

   typedef struct packed {
      state_type             state;
      logic [NonceWidth-1:0] nonce;
   } lane_type;

   function automatic logic [WordWidth-1:0] rotl64(input logic [WordWidth-1:0] x,
                                                   input int r);
      return (x << r) | (x >> (WordWidth - r));
   endfunction

   // First half of a SipRound: v0 += v1 and v2 += v3 in parallel
   function automatic state_type half_a(input state_type s);
      state_type o;
      logic [WordWidth-1:0] a;
      logic [WordWidth-1:0] c;
      a    = s.v0 + s.v1;
      c    = s.v2 + s.v3;
      o.v1 = rotl64(s.v1, RotB1) ^ a;
      o.v0 = rotl64(a, RotA);
      o.v3 = rotl64(s.v3, RotD1) ^ c;
      o.v2 = c;
      return o;
   endfunction

   // Second half: v0 += v3 and v2 += v1 in parallel
   function automatic state_type half_b(input state_type s);
      state_type o;
      logic [WordWidth-1:0] a;
      logic [WordWidth-1:0] c;
      a    = s.v0 + s.v3;
      c    = s.v2 + s.v1;
      o.v0 = a;
      o.v3 = rotl64(s.v3, RotD2) ^ a;
      o.v1 = rotl64(s.v1, RotB2) ^ c;
      o.v2 = rotl64(c, RotA);
      return o;
   endfunction

endpackage

// ===== src/sh24_if.sv =====
interface sh24_req_if;
   logic                             valid;
   logic                             ready;
   logic [sh24_pkg::NonceWidth-1:0]  nonce;

   modport source (output valid, output nonce, input ready);
   modport sink   (input valid, input nonce, output ready);
endinterface

interface sh24_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [sh24_pkg::HashWidth-1:0]   hash_low;

   modport source (output valid, output hash_low, input ready);
   modport sink   (input valid, input hash_low, output ready);
endinterface

// ===== src/siphash24_nonce_hash_core.sv =====
// Channel   Direction  Payload               Handshake
// req_bus   in         nonce[31:0]           valid/ready
// rsp_bus   out        hash_low[31:0]        valid/ready
// csr_*     in         index[1:0], data[63:0] write enable, no wait
//
// One nonce is accepted every cycle unless output backpressure has filled
// the pipeline; each result passes six SipRounds at two half-round stages
// each, plus the output register. Throughput is set by the per-stage
// valid/ready chain: every stage loads when empty or when its item moves on,
// so bubbles fill in. Reset clears all valid bits and the init words; a stalled
// result holds and the stages behind it keep filling until the pipeline is full.
module siphash24_nonce_hash_core (
   input  logic                                 clock,
   input  logic                                 reset,
   sh24_req_if.sink                             req_bus,
   sh24_rsp_if.source                           rsp_bus,
   input  logic                                 csr_wr_en,
   input  logic [sh24_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [sh24_pkg::WordWidth-1:0]       csr_wr_data
);

   localparam int NumRounds = sh24_pkg::NumRounds;

   logic [sh24_pkg::WordWidth-1:0] init0_ff;
   logic [sh24_pkg::WordWidth-1:0] init1_ff;
   logic [sh24_pkg::WordWidth-1:0] init2_ff;
   logic [sh24_pkg::WordWidth-1:0] init3_ff;

   logic               link_valid [NumRounds+1];
   logic               link_ready [NumRounds+1];
   sh24_pkg::lane_type link_data  [NumRounds+1];
   sh24_pkg::lane_type round_in   [NumRounds];

   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic [sh24_pkg::HashWidth-1:0] rsp_hash_ff;
   logic [sh24_pkg::HashWidth-1:0] rsp_hash_in;
   logic                           rsp_load;
   logic [sh24_pkg::WordWidth-1:0] fold;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         init0_ff <= '0;
         init1_ff <= '0;
         init2_ff <= '0;
         init3_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            sh24_pkg::CSR_INIT_WORD0: init0_ff <= csr_wr_data;
            sh24_pkg::CSR_INIT_WORD1: init1_ff <= csr_wr_data;
            sh24_pkg::CSR_INIT_WORD2: init2_ff <= csr_wr_data;
            sh24_pkg::CSR_INIT_WORD3: init3_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // entry: nonce zero-extended into v3
   assign link_valid[0]         = req_bus.valid;
   assign req_bus.ready         = link_ready[0];
   assign link_data[0].state.v0 = init0_ff;
   assign link_data[0].state.v1 = init1_ff;
   assign link_data[0].state.v2 = init2_ff;
   assign link_data[0].state.v3 = init3_ff ^ {{(sh24_pkg::WordWidth -
                                  sh24_pkg::NonceWidth){1'b0}}, req_bus.nonce};
   assign link_data[0].nonce    = req_bus.nonce;

   // round chain, nonce and 0xff injected ahead of the third round
   for (genvar i = 0; i < NumRounds; i++) begin : g_round
      always_comb begin
         round_in[i] = link_data[i];
         if (i == sh24_pkg::InjectRound) begin
            round_in[i].state.v0 = link_data[i].state.v0 ^
               {{(sh24_pkg::WordWidth - sh24_pkg::NonceWidth){1'b0}}, link_data[i].nonce};
            round_in[i].state.v2 = link_data[i].state.v2 ^ sh24_pkg::FinalXorV2;
         end
      end

      sh24_round u_round (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[i]),
         .in_ready  (link_ready[i]),
         .in_data   (round_in[i]),
         .out_valid (link_valid[i+1]),
         .out_ready (link_ready[i+1]),
         .out_data  (link_data[i+1])
      );
   end

   // output register with final fold
   assign rsp_load              = !rsp_valid_ff || rsp_bus.ready;
   assign link_ready[NumRounds] = rsp_load;
   assign fold = link_data[NumRounds].state.v0 ^ link_data[NumRounds].state.v1 ^
                 link_data[NumRounds].state.v2 ^ link_data[NumRounds].state.v3;
   assign rsp_hash_in  = fold[sh24_pkg::HashWidth-1:0];
   assign rsp_valid_in = rsp_load ? link_valid[NumRounds] : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_hash_ff <= rsp_hash_in;
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.hash_low = rsp_hash_ff;

endmodule

// ===== src/sh24_round.sv =====
// One SipRound as two register stages, each with its own valid bit.
module sh24_round (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  sh24_pkg::lane_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output sh24_pkg::lane_type out_data
);

   logic               a_valid_ff;
   logic               a_valid_in;
   sh24_pkg::lane_type a_data_ff;
   sh24_pkg::lane_type a_data_in;
   logic               a_ready;

   logic               b_valid_ff;
   logic               b_valid_in;
   sh24_pkg::lane_type b_data_ff;
   sh24_pkg::lane_type b_data_in;
   logic               b_ready;

   // a stage can load when empty or when its content moves on
   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   // first half round
   always_comb begin
      a_valid_in      = a_ready ? in_valid : a_valid_ff;
      a_data_in.state = sh24_pkg::half_a(in_data.state);
      a_data_in.nonce = in_data.nonce;
   end

   // second half round
   always_comb begin
      b_valid_in      = b_ready ? a_valid_ff : b_valid_ff;
      b_data_in.state = sh24_pkg::half_b(a_data_ff.state);
      b_data_in.nonce = a_data_ff.nonce;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   // payload loads only on a move
   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_data_ff <= a_data_in;
      end
      if (b_ready) begin
         b_data_ff <= b_data_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;

endmodule

// ===== src/sh24_checker.sv =====
// Port-level checks on the nonce hash core.
module sh24_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [sh24_pkg::HashWidth-1:0] rsp_hash
);

   logic [sh24_pkg::CountWidth-1:0] pending_ff;
   logic [sh24_pkg::CountWidth-1:0] pending_in;

   // transactions in flight
   always_comb begin
      pending_in = pending_ff;
      if (req_valid && req_ready) begin
         pending_in = pending_in + 1'b1;
      end
      if (rsp_valid && rsp_ready) begin
         pending_in = pending_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("result without a pending transaction");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= sh24_pkg::CountWidth'(sh24_pkg::PipeDepth))
      else $error("more transactions in flight than pipeline stages");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output backpressure");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hash))
      else $error("stalled result changed");

endmodule

bind siphash24_nonce_hash_core sh24_checker u_sh24_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_hash  (rsp_bus.hash_low)
);

// ===== tb/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sh24_pkg::*;

   localparam int PipeLatency  = 13;
   localparam int QuietLimit   = 3000;
   localparam int ItemsPerRun  = 104;
   localparam int NumRandRuns  = 8;

   typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_type;

   logic clock = 1'b0;
   logic reset;
   logic                     csr_wr_en;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [WordWidth-1:0]     csr_wr_data;

   sh24_req_if req_bus ();
   sh24_rsp_if rsp_bus ();

   siphash24_nonce_hash_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Clock: 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Local copy of the key words, updated as each register write lands
   logic [WordWidth-1:0]  key_words [4];
   logic [NonceWidth-1:0] nonce_backlog [$];
   logic [HashWidth-1:0]  expected_hashes [$];

   int  sender_idle_pct;
   int  receiver_stall_pct;
   int  mismatch_count;
   int  nonces_sent;
   int  hashes_checked;
   int  key_settings;
   int  quiet_cycles;
   logic req_taken;
   logic [HashWidth-1:0] want_hash;

   // ---------------------------------------------------------------
   // Hash predictor
   // ---------------------------------------------------------------
   function automatic logic [WordWidth-1:0] rot_left(input logic [WordWidth-1:0] x,
                                                     input int r);
      logic [2*WordWidth-1:0] twice;
      twice = {x, x} >> (WordWidth - r);
      return twice[WordWidth-1:0];
   endfunction

   function automatic state_type sip_mix(input state_type s);
      state_type t;
      t    = s;
      t.v0 = t.v0 + t.v1;
      t.v1 = rot_left(t.v1, 13) ^ t.v0;
      t.v0 = rot_left(t.v0, 32);
      t.v2 = t.v2 + t.v3;
      t.v3 = rot_left(t.v3, 16) ^ t.v2;
      t.v0 = t.v0 + t.v3;
      t.v3 = rot_left(t.v3, 21) ^ t.v0;
      t.v2 = t.v2 + t.v1;
      t.v1 = rot_left(t.v1, 17) ^ t.v2;
      t.v2 = rot_left(t.v2, 32);
      return t;
   endfunction

   function automatic logic [HashWidth-1:0] predict_hash(input logic [NonceWidth-1:0] nonce);
      state_type            s;
      logic [WordWidth-1:0] m;
      logic [WordWidth-1:0] folded;
      m    = {{(WordWidth-NonceWidth){1'b0}}, nonce};
      s.v0 = key_words[0];
      s.v1 = key_words[1];
      s.v2 = key_words[2];
      s.v3 = key_words[3] ^ m;
      // two compression rounds, then message and finalization injection
      for (int i = 0; i < 2; i++) s = sip_mix(s);
      s.v0 = s.v0 ^ m;
      s.v2 = s.v2 ^ 64'hff;
      for (int i = 0; i < 4; i++) s = sip_mix(s);
      folded = s.v0 ^ s.v1 ^ s.v2 ^ s.v3;
      return folded[HashWidth-1:0];
   endfunction

   task automatic report_mismatch(input string what, input logic [HashWidth-1:0] got,
                                  input logic [HashWidth-1:0] want);
      mismatch_count++;
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
   endtask

   // ---------------------------------------------------------------
   // Request driver: next nonce goes out once the current one is taken
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (nonce_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_bus.valid <= 1'b1;
            req_bus.nonce <= nonce_backlog.pop_front();
         end else begin
            req_bus.valid <= 1'b0;
            req_bus.nonce <= $urandom;
         end
      end
   end

   // Response backpressure
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // ---------------------------------------------------------------
   // Monitor: predict on request transaction, check on response
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_taken    <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;
         if (req_bus.valid && req_bus.ready) begin
            expected_hashes.push_back(predict_hash(req_bus.nonce));
            nonces_sent++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            hashes_checked++;
            if (expected_hashes.size() == 0) begin
               report_mismatch("hash with no nonce outstanding", rsp_bus.hash_low, '0);
            end else begin
               want_hash = expected_hashes.pop_front();
               if (rsp_bus.hash_low !== want_hash)
                  report_mismatch("hash_low", rsp_bus.hash_low, want_hash);
            end
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Watchdog on a stuck handshake
   initial begin
      wait (quiet_cycles >= QuietLimit);
      $display("FAIL siphash24_nonce_hash_core");
      $finish;
   end

   // ---------------------------------------------------------------
   // Sequencing helpers
   // ---------------------------------------------------------------
   task automatic wait_drained();
      while (nonce_backlog.size() != 0 || req_bus.valid || expected_hashes.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_key(input logic [CsrIndexWidth-1:0] idx,
                            input logic [WordWidth-1:0] data);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = data;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      key_words[idx] = data;
   endtask

   task automatic load_keys(input logic [WordWidth-1:0] w0, input logic [WordWidth-1:0] w1,
                            input logic [WordWidth-1:0] w2, input logic [WordWidth-1:0] w3);
      write_key(CSR_INIT_WORD0, w0);
      write_key(CSR_INIT_WORD1, w1);
      write_key(CSR_INIT_WORD2, w2);
      write_key(CSR_INIT_WORD3, w3);
      key_settings++;
   endtask

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IdleNone: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
         end
         IdleSender: begin
            sender_idle_pct    = 68;
            receiver_stall_pct = 0;
         end
         IdleReceiver: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 68;
         end
         default: begin
            sender_idle_pct    = 35;
            receiver_stall_pct = 35;
         end
      endcase
   endtask

   function automatic logic [WordWidth-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // Mostly uniform nonces with a share of edge patterns
   function automatic logic [NonceWidth-1:0] pick_nonce();
      int bit_pos;
      bit_pos = $urandom_range(NonceWidth - 1);
      case ($urandom_range(15))
         0:       return '0;
         1:       return '1;
         2:       return 32'd1 << bit_pos;
         3:       return ~(32'd1 << bit_pos);
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_directed();
      nonce_backlog.push_back(32'h0000_0000);
      nonce_backlog.push_back(32'hffff_ffff);
      nonce_backlog.push_back(32'h0000_0001);
      nonce_backlog.push_back(32'h8000_0000);
      nonce_backlog.push_back(32'h5555_5555);
      nonce_backlog.push_back(32'haaaa_aaaa);
      nonce_backlog.push_back(32'h0000_ffff);
      nonce_backlog.push_back(32'hffff_0000);
      nonce_backlog.push_back(32'h0000_00ff);
   endtask

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   initial begin
      logic [WordWidth-1:0] k0;
      logic [WordWidth-1:0] k1;

      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_index      = '0;
      csr_wr_data    = '0;
      req_bus.valid  = 1'b0;
      req_bus.nonce  = '0;
      rsp_bus.ready  = 1'b0;
      mismatch_count = 0;
      nonces_sent    = 0;
      hashes_checked = 0;
      key_settings   = 1;
      for (int i = 0; i < 4; i++) key_words[i] = '0;
      set_idling(IdleNone);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: all-zero key words straight out of reset
      queue_directed();
      wait_drained();

      // Directed: all-ones key words
      load_keys('1, '1, '1, '1);
      queue_directed();
      wait_drained();

      // Random runs, each loading a key and one of the four idle mixes; every run
      // starts from a drained pipeline
      for (int run = 0; run < NumRandRuns; run++) begin
         k0 = rand_word();
         k1 = rand_word();
         case (run)
            0: load_keys(64'h736f6d6570736575 ^ k0, 64'h646f72616e646f6d ^ k1,
                         64'h6c7967656e657261 ^ k0, 64'h7465646279746573 ^ k1);
            2: load_keys('0, '0, '0, '0);
            3: load_keys('1, '1, '1, '1);
            4: load_keys('0, '1, '0, '1);
            5: load_keys('1, rand_word(), '0, rand_word());
            default: load_keys(rand_word(), rand_word(), rand_word(), rand_word());
         endcase
         set_idling(idle_mode_type'(run % 4));
         for (int n = 0; n < ItemsPerRun; n++) nonce_backlog.push_back(pick_nonce());
         wait_drained();
      end

      repeat (PipeLatency + 4) @(negedge clock);
      if (expected_hashes.size() != 0)
         report_mismatch("hashes never returned", '0, HashWidth'(expected_hashes.size()));

      $display("run covered %0d nonces across %0d key settings and four idle mixes",
               nonces_sent, key_settings);
      $display("%0d hashes compared, %0d mismatches", hashes_checked, mismatch_count);
      if (mismatch_count == 0)
         $display("PASS siphash24_nonce_hash_core");
      else
         $display("FAIL siphash24_nonce_hash_core");
      $finish;
   end

endmodule

// ===== sim.f =====
src/sh24_pkg.sv
src/sh24_if.sv
src/sh24_round.sv
src/siphash24_nonce_hash_core.sv
src/sh24_checker.sv
tb/tb.sv
